// ===== rtl/quadratic_real_roots_macros.svh =====
// Assertion macros shared by the quadratic root block checkers
`ifndef QUADRATIC_REAL_ROOTS_MACROS_SVH
`define QUADRATIC_REAL_ROOTS_MACROS_SVH

// Same-cycle implication, checked outside reset
`define QRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define QRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qrr_pkg.sv =====
// Shared types and constants of the quadratic root block
package qrr_pkg;

  // width of the root and discriminant result fields
  localparam int OUT_W = 34;
  // depth of the queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;

  typedef enum logic [1:0] {
    ST_REAL   = 2'd0,
    ST_NONE   = 2'd1,
    ST_ZERO_A = 2'd2
  } status_t;

  // queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

// ===== rtl/qrr_front.sv =====
// Front end: coefficient products, discriminant and classification
module qrr_front #(
  parameter int CW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [CW-1:0]   coef_a,
  input  logic signed [CW-1:0]   coef_b,
  input  logic signed [CW-1:0]   coef_c,
  input  logic                   q_full,
  output logic                   push,
  output logic signed [2*CW+1:0] f_disc,
  output logic signed [CW-1:0]   f_a,
  output logic signed [CW-1:0]   f_b,
  output qrr_pkg::status_t       f_st
);
  localparam int DW = 2 * CW + 2;

  logic                   f_valid;
  logic signed [2*CW-1:0] bb;
  logic signed [2*CW-1:0] ac;

  assign in_stall = f_valid && q_full;
  assign push     = f_valid && !q_full;

  // product stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  // product stage payload
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      bb  <= coef_b * coef_b;
      ac  <= coef_a * coef_c;
      f_a <= coef_a;
      f_b <= coef_b;
    end
  end

  // exact discriminant and class
  always_comb begin
    f_disc = DW'(bb) - (DW'(ac) <<< 2);
    if (f_disc[DW-1]) begin
      f_st = qrr_pkg::ST_NONE;
    end else if (f_a == '0) begin
      f_st = qrr_pkg::ST_ZERO_A;
    end else begin
      f_st = qrr_pkg::ST_REAL;
    end
  end

endmodule

// ===== rtl/qrr_queue.sv =====
// Small queue decoupling the front end from the back end
module qrr_queue #(
  parameter int W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [W-1:0]       wdata,
  input  logic               pop,
  output logic [W-1:0]       rdata,
  output qrr_pkg::q_flags_t  flags
);
  localparam int D  = qrr_pkg::Q_DEPTH;
  localparam int AW = qrr_pkg::Q_AW;

  logic [W-1:0] mem [D];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign flags.full  = (count == (AW+1)'(D));
  assign flags.empty = (count == '0);
  assign rdata       = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

endmodule

// ===== rtl/qrr_back.sv =====
// Back end: pipelined square root, two pipelined dividers, output register
module qrr_back #(
  parameter int CW = 16,
  parameter int FB = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   b_valid,
  output logic                   pop,
  input  logic signed [2*CW+1:0] b_disc,
  input  logic signed [CW-1:0]   b_a,
  input  logic signed [CW-1:0]   b_b,
  input  qrr_pkg::status_t       b_st,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [qrr_pkg::OUT_W-1:0] root_plus,
  output logic signed [qrr_pkg::OUT_W-1:0] root_minus,
  output logic signed [qrr_pkg::OUT_W-1:0] discriminant,
  output logic [1:0]             status
);
  localparam int DW  = 2 * CW + 2;
  localparam int RW  = CW + 1 + FB;
  localparam int OPW = 2 * RW;
  localparam int NW  = CW + FB + 3;
  localparam int DNW = CW + 1;
  localparam int OW  = qrr_pkg::OUT_W;

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv && b_valid;

  // square root pipeline, one root bit per stage
  logic                  sq_v    [RW+1];
  logic [OPW-1:0]        sq_op   [RW+1];
  logic [RW+1:0]         sq_rem  [RW+1];
  logic [RW-1:0]         sq_root [RW+1];
  logic signed [DW-1:0]  sq_disc [RW+1];
  logic signed [CW-1:0]  sq_a    [RW+1];
  logic signed [CW-1:0]  sq_b    [RW+1];
  qrr_pkg::status_t      sq_st   [RW+1];

  // divider pipelines, one quotient bit per stage
  logic                  dv_v    [NW+1];
  logic [DNW-1:0]        dv_den  [NW+1];
  logic [DNW-1:0]        dv_rp   [NW+1];
  logic [NW-1:0]         dv_np   [NW+1];
  logic                  dv_sp   [NW+1];
  logic [DNW-1:0]        dv_rm   [NW+1];
  logic [NW-1:0]         dv_nm   [NW+1];
  logic                  dv_sm   [NW+1];
  logic signed [DW-1:0]  dv_disc [NW+1];
  qrr_pkg::status_t      dv_st   [NW+1];

  // square root entry
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_op[0]   <= (b_st == qrr_pkg::ST_REAL) ?
                    (OPW'($unsigned(b_disc)) << (2 * FB)) : '0;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_disc[0] <= b_disc;
      sq_a[0]    <= b_a;
      sq_b[0]    <= b_b;
      sq_st[0]   <= b_st;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+3:0] rn;
    logic [RW+3:0] trial;
    logic          ge;

    // trial subtract of one bit pair
    always_comb begin
      rn    = {sq_rem[k], sq_op[k][OPW-1 -: 2]};
      trial = (RW+4)'({sq_root[k], 2'b01});
      ge    = (rn >= trial);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k+1]  <= ge ? (RW+2)'(rn - trial) : (RW+2)'(rn);
        sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
        sq_op[k+1]   <= sq_op[k] << 2;
        sq_disc[k+1] <= sq_disc[k];
        sq_a[k+1]    <= sq_a[k];
        sq_b[k+1]    <= sq_b[k];
        sq_st[k+1]   <= sq_st[k];
      end
    end
  end

  // numerators, denominator and signs for the dividers
  logic signed [NW-1:0] nb;
  logic signed [NW-1:0] rt;
  logic signed [NW-1:0] num_p;
  logic signed [NW-1:0] num_m;
  logic signed [DNW-1:0] den2;
  logic [DNW-1:0]        den_mag;
  logic                  real_st;

  always_comb begin
    real_st = (sq_st[RW] == qrr_pkg::ST_REAL);
    nb      = -(NW'(sq_b[RW]) <<< FB);
    rt      = NW'(sq_root[RW]);
    num_p   = nb + rt;
    num_m   = nb - rt;
    den2    = DNW'(sq_a[RW]) <<< 1;
    den_mag = den2[DNW-1] ? DNW'(-den2) : DNW'(den2);
    if (!real_st) den_mag = DNW'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_den[0]  <= den_mag;
      dv_rp[0]   <= '0;
      dv_rm[0]   <= '0;
      dv_np[0]   <= num_p[NW-1] ? NW'(-num_p) : NW'(num_p);
      dv_nm[0]   <= num_m[NW-1] ? NW'(-num_m) : NW'(num_m);
      dv_sp[0]   <= num_p[NW-1] ^ sq_a[RW][CW-1];
      dv_sm[0]   <= num_m[NW-1] ^ sq_a[RW][CW-1];
      dv_disc[0] <= sq_disc[RW];
      dv_st[0]   <= sq_st[RW];
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DNW:0] r2p;
    logic [DNW:0] r2m;
    logic         gep;
    logic         gem;

    // restoring step on both quotients
    always_comb begin
      r2p = {dv_rp[j], dv_np[j][NW-1]};
      r2m = {dv_rm[j], dv_nm[j][NW-1]};
      gep = (r2p >= {1'b0, dv_den[j]});
      gem = (r2m >= {1'b0, dv_den[j]});
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rp[j+1]   <= gep ? DNW'(r2p - {1'b0, dv_den[j]}) : DNW'(r2p);
        dv_rm[j+1]   <= gem ? DNW'(r2m - {1'b0, dv_den[j]}) : DNW'(r2m);
        dv_np[j+1]   <= {dv_np[j][NW-2:0], gep};
        dv_nm[j+1]   <= {dv_nm[j][NW-2:0], gem};
        dv_sp[j+1]   <= dv_sp[j];
        dv_sm[j+1]   <= dv_sm[j];
        dv_den[j+1]  <= dv_den[j];
        dv_disc[j+1] <= dv_disc[j];
        dv_st[j+1]   <= dv_st[j];
      end
    end
  end

  // valid chain through every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= RW; i++) sq_v[i] <= 1'b0;
      for (int i = 0; i <= NW; i++) dv_v[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= b_valid;
      for (int i = 0; i < RW; i++) sq_v[i+1] <= sq_v[i];
      dv_v[0] <= sq_v[RW];
      for (int i = 0; i < NW; i++) dv_v[i+1] <= dv_v[i];
      out_valid <= dv_v[NW];
    end
  end

  // sign fix and output register
  logic signed [NW-1:0] qp;
  logic signed [NW-1:0] qm;

  always_comb begin
    qp = dv_sp[NW] ? -$signed(dv_np[NW]) : $signed(dv_np[NW]);
    qm = dv_sm[NW] ? -$signed(dv_nm[NW]) : $signed(dv_nm[NW]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root_plus    <= (dv_st[NW] == qrr_pkg::ST_REAL) ? OW'(qp) : '0;
      root_minus   <= (dv_st[NW] == qrr_pkg::ST_REAL) ? OW'(qm) : '0;
      discriminant <= OW'(dv_disc[NW]);
      status       <= dv_st[NW];
    end
  end

endmodule

// ===== rtl/quadratic_real_roots.sv =====
// Top level of the quadratic real root block
//
// Input channel: in_valid/in_stall carry one transaction of coef_a, coef_b,
// coef_c (signed integers). Output channel: out_valid/out_stall carry one
// transaction of root_plus, root_minus (signed, FRAC_BITS fraction bits,
// truncated toward zero), the exact discriminant and status (0 real roots,
// 1 no real roots, 2 a is zero; roots read zero unless status is 0).
// One result transaction follows each input transaction, in order.
// Throughput: one transaction per cycle while out_stall is low. Results pass
// through the product stage, the queue, the square root pipeline (one root
// bit per stage), the divider pipelines (one quotient bit per stage) and the
// output register.
// A four-entry queue sits between the discriminant front end and the root
// back end. When out_stall is high the back end holds, the queue fills, and
// in_stall rises once the queue is full. Reset empties all pipeline stages.
module quadratic_real_roots #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COEF_WIDTH-1:0]   coef_a,
  input  logic signed [COEF_WIDTH-1:0]   coef_b,
  input  logic signed [COEF_WIDTH-1:0]   coef_c,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [qrr_pkg::OUT_W-1:0] root_plus,
  output logic signed [qrr_pkg::OUT_W-1:0] root_minus,
  output logic signed [qrr_pkg::OUT_W-1:0] discriminant,
  output logic [1:0]                     status
);
  localparam int CW = COEF_WIDTH;
  localparam int DW = 2 * CW + 2;
  localparam int QW = DW + 2 * CW + 2;

  logic                  push;
  logic                  pop;
  logic signed [DW-1:0]  f_disc;
  logic signed [CW-1:0]  f_a;
  logic signed [CW-1:0]  f_b;
  qrr_pkg::status_t      f_st;
  qrr_pkg::q_flags_t     qf;
  logic [QW-1:0]         q_rd;
  qrr_pkg::status_t      b_st;

  qrr_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .coef_a   (coef_a),
    .coef_b   (coef_b),
    .coef_c   (coef_c),
    .q_full   (qf.full),
    .push     (push),
    .f_disc   (f_disc),
    .f_a      (f_a),
    .f_b      (f_b),
    .f_st     (f_st)
  );

  qrr_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_disc, f_a, f_b, f_st}),
    .pop   (pop),
    .rdata (q_rd),
    .flags (qf)
  );

  // unpack the queue head status
  assign b_st = qrr_pkg::status_t'(q_rd[1:0]);

  qrr_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .b_valid      (!qf.empty),
    .pop          (pop),
    .b_disc       ($signed(q_rd[QW-1 -: DW])),
    .b_a          ($signed(q_rd[2*CW+1 -: CW])),
    .b_b          ($signed(q_rd[CW+1 -: CW])),
    .b_st         (b_st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .root_plus    (root_plus),
    .root_minus   (root_minus),
    .discriminant (discriminant),
    .status       (status)
  );

endmodule

// ===== rtl/qrr_checker.sv =====
// Port-level checker for the quadratic root block, bound to the top level
`include "quadratic_real_roots_macros.svh"

module qrr_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [qrr_pkg::OUT_W-1:0] root_plus,
  input logic [qrr_pkg::OUT_W-1:0] root_minus,
  input logic [qrr_pkg::OUT_W-1:0] discriminant,
  input logic [1:0]        status
);
  localparam int RESW = 3 * qrr_pkg::OUT_W + 2;

  logic            out_wait;
  logic [RESW-1:0] res;
  logic            neg_disc;
  logic            zero_roots;
  logic            is_none;
  logic            is_zero_a;
  logic            is_real;

  // result summary terms
  assign out_wait   = out_valid && out_stall;
  assign res        = {root_plus, root_minus, discriminant, status};
  assign neg_disc   = discriminant[qrr_pkg::OUT_W-1];
  assign zero_roots = (root_plus == '0) && (root_minus == '0);
  assign is_none    = out_valid && (status == qrr_pkg::ST_NONE);
  assign is_zero_a  = out_valid && (status == qrr_pkg::ST_ZERO_A);
  assign is_real    = out_valid && (status == qrr_pkg::ST_REAL);

  // a stalled result stays put
  `QRR_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(res), "stalled result changed")
  // no real roots means a negative discriminant and zero roots
  `QRR_ASSERT_NOW(a_none_neg, is_none, neg_disc && zero_roots, "no-root result inconsistent")
  // zero a gives zero roots
  `QRR_ASSERT_NOW(a_zero_a, is_zero_a, zero_roots, "zero-a result has roots")
  // real roots never come with a negative discriminant
  `QRR_ASSERT_NOW(a_real_pos, is_real, !neg_disc, "real roots with negative discriminant")

endmodule

bind quadratic_real_roots qrr_checker u_qrr_checker (.*);

// ===== tb/tb_quadratic_real_roots.sv =====
// Self-checking testbench for the quadratic real root block
module tb_quadratic_real_roots;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int LAT = 2 * (CW + FB) + 8;
  localparam int N_RANDOM = 800;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    bit pause;
  } coef_set_t;

  typedef struct {
    logic signed [qrr_pkg::OUT_W-1:0] rp;
    logic signed [qrr_pkg::OUT_W-1:0] rm;
    logic signed [qrr_pkg::OUT_W-1:0] disc;
    qrr_pkg::status_t st;
  } roots_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [CW-1:0] coef_a, coef_b, coef_c;
  logic signed [qrr_pkg::OUT_W-1:0] root_plus, root_minus, discriminant;
  logic [1:0] status;

  coef_set_t pending_sets[$];
  roots_t expected_roots[$];
  int errors = 0;
  longint cycles = 0;
  bit stim_done = 0;
  int in_gap = 0, out_gap = 0;
  bit waiting_drain = 0;

  quadratic_real_roots u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .root_plus(root_plus), .root_minus(root_minus),
    .discriminant(discriminant), .status(status)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // floor(sqrt(d)) with FB fraction bits, one bit pair at a time
  function automatic longint unsigned frac_sqrt(longint unsigned d);
    longint unsigned rem, r, trial;
    rem = 0;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((d >> (2 * i)) & 64'd3);
      trial = (r << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        r = (r << 1) | 64'd1;
      end else begin
        r <<= 1;
      end
    end
    for (int i = 0; i < FB; i++) begin
      rem <<= 2;
      trial = (r << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        r = (r << 1) | 64'd1;
      end else begin
        r <<= 1;
      end
    end
    return r;
  endfunction

  function automatic roots_t solve_quadratic(coef_set_t s);
    roots_t o;
    longint da, db, dc, d, q, nb, den;
    da = s.a; db = s.b; dc = s.c;
    d = db * db - 4 * da * dc;
    o.disc = d[qrr_pkg::OUT_W-1:0];
    o.rp = '0;
    o.rm = '0;
    if (d < 0) begin
      o.st = qrr_pkg::ST_NONE;
    end else if (da == 0) begin
      o.st = qrr_pkg::ST_ZERO_A;
    end else begin
      q = longint'(frac_sqrt(d));
      nb = -db * (longint'(1) << FB);
      den = 2 * da;
      // SV division truncates toward zero
      o.rp = 34'((nb + q) / den);
      o.rm = 34'((nb - q) / den);
      o.st = qrr_pkg::ST_REAL;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic add_set(int a, int b, int c, bit pause = 0);
    coef_set_t s;
    s.a = a; s.b = b; s.c = c; s.pause = pause;
    pending_sets.push_back(s);
  endtask

  function automatic int rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 20)) - 10;
      2: return int'($urandom_range(0, 600)) - 300;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // stimulus
  initial begin
    int a, b, c;
    add_set(1, -3, 2);
    add_set(1, 0, 1);
    add_set(0, 5, 7);
    add_set(0, 0, 0);
    add_set(0, -32768, -32768);
    add_set(-32768, -32768, 32767);
    add_set(32767, -32768, -32768);
    add_set(-32768, 32767, -32768);
    add_set(32767, 32767, 32767);
    add_set(-32768, -32768, -32768);
    add_set(1, 2, 1);
    add_set(-1, 0, 4);
    add_set(3, 1, -5);
    add_set(-7, 3, 2, 1);
    add_set(2, 5, -3);
    add_set(1, 1, 1);
    add_set(-1, -1, 1);
    add_set(32767, 0, -32768);
    for (int i = 0; i < N_RANDOM; i++) begin
      a = rand_coef(); b = rand_coef(); c = rand_coef();
      // mostly real roots: flip c sign so that 4ac tends negative
      if ($urandom_range(0, 3) != 0 && a * c > 0) c = -c;
      if (c > 32767) c = 32767;
      add_set(a, b, c, i == N_RANDOM / 2);
    end
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      coef_a <= '0; coef_b <= '0; coef_c <= '0;
      in_gap <= $urandom_range(0, 4);
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_roots.push_back(solve_quadratic(
        coef_set_t'{coef_a, coef_b, coef_c, 1'b0}));
      if (waiting_drain) begin
        in_valid <= 1'b0;
        if (expected_roots.size() == 0 && !in_valid) waiting_drain <= 1'b0;
      end else if (in_gap > 0 || pending_sets.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else if (pending_sets[0].pause) begin
        // hold off until every result has come back
        pending_sets[0].pause = 1'b0;
        in_valid <= 1'b0;
        waiting_drain <= 1'b1;
      end else begin
        coef_set_t s;
        s = pending_sets.pop_front();
        in_valid <= 1'b1;
        coef_a <= s.a; coef_b <= s.b; coef_c <= s.c;
        in_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    roots_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          e = expected_roots.pop_front();
          if (root_plus !== e.rp) report_mismatch("root_plus", root_plus, e.rp);
          if (root_minus !== e.rm) report_mismatch("root_minus", root_minus, e.rm);
          if (discriminant !== e.disc)
            report_mismatch("discriminant", discriminant, e.disc);
          if (status !== e.st) report_mismatch("status", status, e.st);
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // reset and end of run
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    coef_a = '0; coef_b = '0; coef_c = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pending_sets.size() == 0 && !in_valid);
    @(posedge clk);
    wait (expected_roots.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
